// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mdc_pkg.sv =====
package mdc_pkg;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 8;
  localparam int CORE_IN_W = 1;
  localparam int ADDR_SPAN = 1 << ADDR_W;

  localparam int CORE_COUNT_DEF = 2;
  localparam int NUM_SETS_DEF   = 2;
  localparam int MEM_WORDS_DEF  = 32;

  typedef enum logic [1:0] {
    ST_INVALID   = 2'd0,
    ST_SHARED    = 2'd1,
    ST_EXCLUSIVE = 2'd2,
    ST_MODIFIED  = 2'd3
  } mesi_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [CORE_IN_W-1:0]     core;
    cmd_t                     cmd;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [CORE_IN_W-1:0]     core_out;
    cmd_t                     cmd_out;
    logic [ADDR_W-1:0]        line_address;
    logic signed [DATA_W-1:0] line_data;
    mesi_t                    line_state;
  } rsp_t;

endpackage

// ===== hw/rtl/mdc_ram.sv =====
module mdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mesi_direct_mapped_coherence_top.sv =====
// MESI coherence over CORE_COUNT direct-mapped caches of one-word lines that
// share one memory of MEM_WORDS signed bytes.
//
// Request channel (req_valid / req_ready / req): one transaction is one
// core's read or write of a byte at a word address. Response channel
// (rsp_valid / rsp_ready / rsp): one transaction per request, in order,
// reporting the accessed line's tag, data and MESI state afterwards.
//
// The accepting edge registers the request and the memory read into stage 1;
// the commit edge resolves the snoop, updates lines and memory and loads the
// response register. Throughput: one transaction per cycle unless the
// receiver stalls; the memory read port is used once per request and a
// writeback from the transaction ahead is forwarded.
//
// When the receiver stalls, the response register holds; stage 1 still
// takes one more request, then req_ready drops until rsp_ready returns.
//
// Reset (rst, synchronous): all lines go Invalid and every memory word reads
// as zero through per-word valid flags; no clearing pass, the block accepts
// a request in the first cycle after reset.
module mesi_direct_mapped_coherence_top #(
  parameter int CORE_COUNT = mdc_pkg::CORE_COUNT_DEF,
  parameter int NUM_SETS   = mdc_pkg::NUM_SETS_DEF,
  parameter int MEM_WORDS  = mdc_pkg::MEM_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mdc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mdc_pkg::rsp_t rsp
);

  import mdc_pkg::*;

  localparam int CORE_W = $clog2(CORE_COUNT);
  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  // address -> set and address -> memory word, constant tables
  logic [SET_W-1:0]  set_lut  [ADDR_SPAN];
  logic [MEM_AW-1:0] midx_lut [ADDR_SPAN];

  for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_lut
    localparam int SetIdx = g % NUM_SETS;
    localparam int MemIdx = g % MEM_WORDS;
    assign set_lut[g]  = SET_W'(SetIdx);
    assign midx_lut[g] = MEM_AW'(MemIdx);
  end

  // handshake
  logic s1_valid;
  logic commit;
  logic accept;

  assign commit    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || commit;
  assign accept    = req_valid && req_ready;

  // shared memory: RAM plus per-word written flags
  logic                     mem_we;
  logic [MEM_AW-1:0]        mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0]        ram_rdata;
  logic [MEM_WORDS-1:0]     mem_vld;
  logic [MEM_AW-1:0]        req_midx;

  assign req_midx = midx_lut[req.address];

  mdc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MEM_WORDS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (accept),
    .raddr(req_midx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (mem_we) begin
      mem_vld[mem_waddr] <= 1'b1;
    end
  end

  // stage 1: registered request, its set, its memory word
  req_t                     s1_req;
  logic [SET_W-1:0]         s1_set;
  logic [MEM_AW-1:0]        s1_aidx;
  logic                     s1_mvld;
  logic                     fwd_hit;
  logic signed [DATA_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  // a writeback committed on the same edge as the read is not seen by the
  // RAM read; capture it here so stage 2 picks it up
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req   <= req;
      s1_set   <= set_lut[req.address];
      s1_aidx  <= req_midx;
      s1_mvld  <= mem_vld[req_midx];
      fwd_hit  <= mem_we && (mem_waddr == req_midx);
      fwd_data <= mem_wdata;
    end
  end

  // cache lines, one small array per core, read at the request's set
  logic [ADDR_W-1:0]        tags [CORE_COUNT][NUM_SETS];
  logic signed [DATA_W-1:0] vals [CORE_COUNT][NUM_SETS];
  mesi_t                    sts  [CORE_COUNT][NUM_SETS];

  logic [ADDR_W-1:0]        tag_rd [CORE_COUNT];
  logic signed [DATA_W-1:0] val_rd [CORE_COUNT];
  mesi_t                    st_rd  [CORE_COUNT];

  always_comb begin
    for (int i = 0; i < CORE_COUNT; i++) begin
      tag_rd[i] = tags[i][s1_set];
      val_rd[i] = vals[i][s1_set];
      st_rd[i]  = sts[i][s1_set];
    end
  end

  // stage 2: snoop and line update
  logic [CORE_W-1:0]        me_core;
  logic [ADDR_W-1:0]        addr;
  logic [ADDR_W-1:0]        my_tag;
  logic signed [DATA_W-1:0] my_val;
  mesi_t                    my_st;
  logic                     tag_diff;
  logic                     conflict;
  logic [MEM_AW-1:0]        wb_idx;
  logic signed [DATA_W-1:0] mem_a;
  logic signed [DATA_W-1:0] mem_now;
  logic                     peer_found;
  logic signed [DATA_W-1:0] peer_val;
  logic [ADDR_W-1:0]        new_tag;
  logic signed [DATA_W-1:0] new_val;
  mesi_t                    new_st;
  mesi_t                    peer_st [CORE_COUNT];

  assign me_core = CORE_W'(s1_req.core);
  assign addr    = s1_req.address;

  always_comb begin
    my_tag   = tag_rd[me_core];
    my_val   = val_rd[me_core];
    my_st    = st_rd[me_core];
    tag_diff = (my_tag != addr);
    // a dirty or shared line under another tag is written back first
    conflict = tag_diff && (my_st == ST_MODIFIED || my_st == ST_SHARED);
    wb_idx   = midx_lut[my_tag];
    mem_a    = fwd_hit ? fwd_data : (s1_mvld ? $signed(ram_rdata) : '0);
    // memory at the address after the writeback
    mem_now  = (conflict && wb_idx == s1_aidx) ? my_val : mem_a;

    // highest valid peer copy supplies the data
    peer_found = 1'b0;
    peer_val   = '0;
    for (int i = 0; i < CORE_COUNT; i++) begin
      if (CORE_W'(i) != me_core && tag_rd[i] == addr && st_rd[i] != ST_INVALID) begin
        peer_found = 1'b1;
        peer_val   = val_rd[i];
      end
    end

    new_tag = my_tag;
    new_val = conflict ? mem_now : my_val;
    new_st  = my_st;
    for (int i = 0; i < CORE_COUNT; i++) begin
      peer_st[i] = st_rd[i];
    end

    if (s1_req.cmd == CMD_WRITE) begin
      new_tag = addr;
      new_val = s1_req.write_data;
      new_st  = ST_MODIFIED;
      for (int i = 0; i < CORE_COUNT; i++) begin
        if (CORE_W'(i) != me_core && tag_rd[i] == addr) begin
          peer_st[i] = ST_INVALID;
        end
      end
    end else if (tag_diff || my_st == ST_INVALID) begin
      new_tag = addr;
      if (peer_found) begin
        new_val = peer_val;
        new_st  = ST_SHARED;
        for (int i = 0; i < CORE_COUNT; i++) begin
          if (CORE_W'(i) != me_core && tag_rd[i] == addr && st_rd[i] != ST_INVALID) begin
            peer_st[i] = ST_SHARED;
          end
        end
      end else begin
        new_val = mem_now;
        new_st  = ST_EXCLUSIVE;
      end
    end
  end

  assign mem_we    = commit && conflict;
  assign mem_waddr = wb_idx;
  assign mem_wdata = my_val;

  // line states reset to Invalid; tag and data are only read behind a
  // valid state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORE_COUNT; i++) begin
        for (int s = 0; s < NUM_SETS; s++) begin
          sts[i][s] <= ST_INVALID;
        end
      end
    end else if (commit) begin
      for (int i = 0; i < CORE_COUNT; i++) begin
        if (CORE_W'(i) == me_core) begin
          sts[i][s1_set] <= new_st;
        end else begin
          sts[i][s1_set] <= peer_st[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      for (int i = 0; i < CORE_COUNT; i++) begin
        if (CORE_W'(i) == me_core) begin
          tags[i][s1_set] <= new_tag;
          vals[i][s1_set] <= new_val;
        end
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.core_out     <= s1_req.core;
      rsp.cmd_out      <= s1_req.cmd;
      rsp.line_address <= new_tag;
      rsp.line_data    <= new_val;
      rsp.line_state   <= new_st;
    end
  end

endmodule

// ===== hw/rtl/mdc_checker.sv =====
`include "assert_macros.svh"

module mdc_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input mdc_pkg::rsp_t rsp
);

  import mdc_pkg::*;

  `ASSERT_NXT_ALWAYS(a_rst_clears_rsp, clk, rst, !rsp_valid, "response valid after reset")

  `ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled response changed")

  `ASSERT_IMP(a_write_modified, clk, rst, rsp_valid && rsp.cmd_out == CMD_WRITE, rsp.line_state == ST_MODIFIED, "write did not leave line Modified")

  `ASSERT_IMP(a_read_valid, clk, rst, rsp_valid && rsp.cmd_out == CMD_READ, rsp.line_state != ST_INVALID, "read left line Invalid")

  `ASSERT_IMP(a_ready_when_free, clk, rst, !rsp_valid || rsp_ready, req_ready, "request stalled with response side free")

endmodule

bind mesi_direct_mapped_coherence_top mdc_checker u_mdc_checker (.*);
